/* design/newu_pkg.sv */
// newu_pkg: shared constants and helper functions for the neighbor edge weight unit.
// Holds the register map, field widths and the softplus weight table generator.
// No dependencies.
package newu_pkg;

  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int TABLE_ENTRIES_DEF = 256;

  localparam int COLOR_W     = 8;
  localparam int PIX_W       = 3 * COLOR_W;
  localparam int CUE_W       = 16;
  localparam int DIST_W      = 18;
  localparam int SPAN_LOG2   = 18;
  localparam int IWIDTH_W    = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [IWIDTH_W-1:0] WIDTH_RESET = IWIDTH_W'(640);
  localparam logic [CUE_W-1:0]    FLOOR_RESET = CUE_W'(9830);

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_WEIGHT = CFG_INDEX_W'(1);

  localparam logic [63:0] COLOR_SCALE = 64'd80;
  localparam logic [63:0] Q31_ONE     = 64'h0000_0000_8000_0000;
  localparam logic [63:0] E_INV_Q31   = 64'd790015084;

  // squared RGB distance of two packed pixels
  function automatic logic [DIST_W-1:0] sq_dist(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [COLOR_W-1:0]   ad;
    logic [2*COLOR_W-1:0] sq;
    logic [DIST_W-1:0]    acc;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      if (a[c*COLOR_W +: COLOR_W] >= b[c*COLOR_W +: COLOR_W]) begin
        ad = a[c*COLOR_W +: COLOR_W] - b[c*COLOR_W +: COLOR_W];
      end else begin
        ad = b[c*COLOR_W +: COLOR_W] - a[c*COLOR_W +: COLOR_W];
      end
      sq  = ad * ad;
      acc = acc + DIST_W'(sq);
    end
    return acc;
  endfunction

  // restoring divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + exp(-x)), x in Q31, rounded to Q0.16
  function automatic logic [CUE_W-1:0] softplus_q16(input logic [63:0] x);
    logic [63:0] n;
    logic [63:0] r;
    longint      sum;
    logic [63:0] term;
    logic [63:0] u;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] acc;
    n    = x >> 31;
    r    = x & (Q31_ONE - 64'd1);
    sum  = longint'(Q31_ONE);
    term = Q31_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * r) >> 31, 64'(k));
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    u = 64'(sum);
    if (n >= 64'd64) begin
      u = '0;
    end else begin
      for (logic [63:0] j = 0; j < n; j++) begin
        u = (u * E_INV_Q31) >> 31;
      end
    end
    z   = udiv64(u << 31, 64'd2 * Q31_ONE + u);
    z2  = (z * z) >> 31;
    p   = z;
    acc = '0;
    for (int k = 0; k < 16; k++) begin
      acc = acc + udiv64(p, 64'(2 * k + 1));
      p   = (p * z2) >> 31;
    end
    acc = 64'd2 * acc;
    acc = (acc + 64'd16384) >> 15;
    if (acc > 64'd65535) begin
      acc = 64'd65535;
    end
    return acc[CUE_W-1:0];
  endfunction

  // table entry k of te entries over a span of 2^SPAN_LOG2
  function automatic logic [CUE_W-1:0] weight_entry(input logic [63:0] k,
                                                    input logic [63:0] te);
    logic [63:0] x;
    x = udiv64((k << SPAN_LOG2) << 31, te * COLOR_SCALE * COLOR_SCALE);
    return softplus_q16(x);
  endfunction

endpackage

/* design/neighbor_edge_weight_unit.sv */
// neighbor_edge_weight_unit: color-distance smoothness weights to left and upper neighbor.
// Line buffer in one synchronous RAM, 5-stage weight pipeline per direction.
// Depends on newu_pkg.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  pixel   | pixel_valid/pixel_ready| red, green, blue, start_of_frame
//  cue     | cue_valid/cue_ready    | horizontal_valid/_cue, vertical_valid/_cue
//  cfg     | cfg_valid/cfg_ready    | cfg_index, cfg_data (always ready)
//
// One item per clock unless cue_ready stalls it; each result passes through 5 registers
// (RAM read, distance, table lookup, interpolation multiply, floor/output register).
// The row RAM is read and written once per item at the same address (read-first).
// Stalls on cue back up stage by stage; empty stages still take items.
// Synchronous reset clears control and config; the row RAM is not cleared.
module neighbor_edge_weight_unit #(
  parameter int MAX_WIDTH     = newu_pkg::MAX_WIDTH_DEF,
  parameter int TABLE_ENTRIES = newu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  logic [newu_pkg::COLOR_W-1:0]      red,
  input  logic [newu_pkg::COLOR_W-1:0]      green,
  input  logic [newu_pkg::COLOR_W-1:0]      blue,
  input  logic                              start_of_frame,
  output logic                              cue_valid,
  input  logic                              cue_ready,
  output logic                              horizontal_valid,
  output logic [newu_pkg::CUE_W-1:0]        horizontal_cue,
  output logic                              vertical_valid,
  output logic [newu_pkg::CUE_W-1:0]        vertical_cue,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [newu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [newu_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import newu_pkg::*;

  localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW       = (CW + 1 > IWIDTH_W) ? CW + 1 : IWIDTH_W;
  localparam int TABLE_IW = $clog2(TABLE_ENTRIES + 1);
  localparam int TW       = DIST_W + TABLE_IW;
  localparam int PROD_W   = (CUE_W + 1) + (SPAN_LOG2 + 1);
  localparam int Q_W      = PROD_W - SPAN_LOG2;

  // weight table
  logic [CUE_W-1:0] wtab [TABLE_ENTRIES+1];
  for (genvar gi = 0; gi <= TABLE_ENTRIES; gi++) begin : g_tab
    localparam logic [CUE_W-1:0] ENTRY = weight_entry(64'(gi), 64'(TABLE_ENTRIES));
    assign wtab[gi] = ENTRY;
  end

  // config and row tracking
  logic [IWIDTH_W-1:0] image_width;
  logic [CUE_W-1:0]    floor_weight;
  logic [CW-1:0]       column_count;
  logic                past_first_row;
  logic [PIX_W-1:0]    left_pixel;
  logic [PIX_W-1:0]    row_store [MAX_WIDTH];

  logic                accept;
  logic [PIX_W-1:0]    pix;
  logic [CW-1:0]       col;
  logic                upper_ok;
  logic [WW-1:0]       eff_width;
  logic [WW-1:0]       col_plus;
  logic                wrap;

  // pipeline
  logic [3:0]          stage_valid;
  logic [3:0]          ld;
  logic                ld_out;

  logic [PIX_W-1:0]    s1_pix;
  logic [PIX_W-1:0]    s1_left;
  logic [PIX_W-1:0]    above_q;
  logic                s1_hv;
  logic                s1_vv;

  logic [DIST_W-1:0]   s2_dist [2];
  logic [1:0]          s2_cv;

  logic [CUE_W-1:0]    s3_base  [2];
  logic signed [CUE_W:0] s3_slope [2];
  logic [SPAN_LOG2-1:0] s3_frac [2];
  logic [1:0]          s3_cv;

  logic [CUE_W-1:0]    s4_base [2];
  logic signed [PROD_W-1:0] s4_prod [2];
  logic [1:0]          s4_cv;

  logic [DIST_W-1:0]   pair_dist [2];
  logic [TW-1:0]       scaled [2];
  logic [TABLE_IW-1:0] tidx [2];
  logic [TABLE_IW-1:0] tidx_n [2];
  logic signed [PROD_W-1:0] prod [2];
  logic signed [Q_W-1:0] quot [2];
  logic signed [Q_W-1:0] wval [2];
  logic [CUE_W-1:0]    weight [2];

  assign cfg_ready = 1'b1;
  assign pix       = {red, green, blue};
  assign accept    = pixel_valid && pixel_ready;

  always_comb begin
    ld_out      = !cue_valid || cue_ready;
    ld[3]       = !stage_valid[3] || ld_out;
    ld[2]       = !stage_valid[2] || ld[3];
    ld[1]       = !stage_valid[1] || ld[2];
    ld[0]       = !stage_valid[0] || ld[1];
    pixel_ready = ld[0];
  end

  always_comb begin
    if (WW'(image_width) < WW'(2)) begin
      eff_width = WW'(2);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(image_width);
    end
    col      = start_of_frame ? '0 : column_count;
    upper_ok = start_of_frame ? 1'b0 : past_first_row;
    col_plus = WW'(col) + WW'(1);
    wrap     = col_plus >= eff_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= WIDTH_RESET;
      floor_weight   <= FLOOR_RESET;
      column_count   <= '0;
      past_first_row <= 1'b0;
      left_pixel     <= '0;
      stage_valid    <= '0;
      cue_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[IWIDTH_W-1:0];
          REG_FLOOR_WEIGHT: floor_weight <= cfg_data[CUE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        left_pixel     <= pix;
        column_count   <= wrap ? '0 : col_plus[CW-1:0];
        past_first_row <= wrap || upper_ok;
      end
      if (ld[0]) stage_valid[0] <= pixel_valid;
      if (ld[1]) stage_valid[1] <= stage_valid[0];
      if (ld[2]) stage_valid[2] <= stage_valid[1];
      if (ld[3]) stage_valid[3] <= stage_valid[2];
      if (ld_out) cue_valid <= stage_valid[3];
    end
  end

  // line buffer, read-first
  always_ff @(posedge clk) begin
    if (accept) begin
      above_q        <= row_store[col];
      row_store[col] <= pix;
      s1_pix         <= pix;
      s1_left        <= left_pixel;
      s1_hv          <= (col != '0);
      s1_vv          <= upper_ok;
    end
  end

  // lane 0: left neighbor, lane 1: pixel above
  always_comb begin
    pair_dist[0] = sq_dist(s1_left, s1_pix);
    pair_dist[1] = sq_dist(above_q, s1_pix);
    for (int l = 0; l < 2; l++) begin
      scaled[l] = TW'(s2_dist[l]) * TW'(TABLE_ENTRIES);
      tidx[l]   = scaled[l][TW-1 -: TABLE_IW];
      tidx_n[l] = tidx[l] + TABLE_IW'(1);
      prod[l]   = s3_slope[l] * $signed({1'b0, s3_frac[l]});
      // divide by span, truncating toward zero
      quot[l]   = s4_prod[l][PROD_W-1:SPAN_LOG2]
                + Q_W'(s4_prod[l][PROD_W-1] && (s4_prod[l][SPAN_LOG2-1:0] != '0));
      wval[l]   = $signed(Q_W'(s4_base[l])) + quot[l];
      if (wval[l] < $signed(Q_W'(floor_weight))) begin
        weight[l] = floor_weight;
      end else begin
        weight[l] = wval[l][CUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_dist[0] <= pair_dist[0];
      s2_dist[1] <= pair_dist[1];
      s2_cv      <= {s1_vv, s1_hv};
    end
    if (ld[2]) begin
      for (int l = 0; l < 2; l++) begin
        s3_base[l]  <= wtab[tidx[l]];
        s3_slope[l] <= $signed({1'b0, wtab[tidx_n[l]]}) - $signed({1'b0, wtab[tidx[l]]});
        s3_frac[l]  <= scaled[l][SPAN_LOG2-1:0];
      end
      s3_cv <= s2_cv;
    end
    if (ld[3]) begin
      for (int l = 0; l < 2; l++) begin
        s4_base[l] <= s3_base[l];
        s4_prod[l] <= prod[l];
      end
      s4_cv <= s3_cv;
    end
    if (ld_out) begin
      horizontal_valid <= s4_cv[0];
      horizontal_cue   <= s4_cv[0] ? weight[0] : '0;
      vertical_valid   <= s4_cv[1];
      vertical_cue     <= s4_cv[1] ? weight[1] : '0;
    end
  end

  a_sof_no_neighbors: assert property (@(posedge clk) disable iff (rst)
    accept && start_of_frame |=> !s1_hv && !s1_vv)
    else $error("start of frame item got a neighbor flag");

  a_wrap_sets_row: assert property (@(posedge clk) disable iff (rst)
    accept && wrap |=> past_first_row && (column_count == '0))
    else $error("row end did not wrap the column count");

  a_bubble_fill: assert property (@(posedge clk) disable iff (rst)
    stage_valid[0] && !stage_valid[1] |=> stage_valid[1])
    else $error("item did not move into an empty stage");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !cue_valid && (stage_valid == '0))
    else $error("pipeline not empty after reset");

endmodule

/* tb/sv/neighbor_edge_weight_unit_test.sv */
`timescale 1ns / 100ps
// neighbor_edge_weight_unit_test: self-checking bench for the neighbor edge weight unit.
// Streams RGB frames under several width/floor settings and checks every cue item
// against an in-bench predictor. Depends on newu_pkg and neighbor_edge_weight_unit.
module neighbor_edge_weight_unit_test;

  localparam int                LUT_SIZE    = newu_pkg::TABLE_ENTRIES_DEF;
  localparam int                ROW_DEPTH   = newu_pkg::MAX_WIDTH_DEF;
  localparam longint            SPAN        = 262144;
  localparam longint unsigned   ONE_Q31     = 64'h8000_0000;
  localparam longint unsigned   EXP_M1_Q31  = 64'd790015084;
  localparam int                STALL_LIMIT = 2000;
  localparam int                PHASES      = 12;

  typedef struct packed {
    logic        h_valid;
    logic [15:0] h_cue;
    logic        v_valid;
    logic [15:0] v_cue;
  } cue_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       sof;
    cue_t       cues;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                pixel_valid = 1'b0;
  logic                                pixel_ready;
  logic [7:0]                          red = '0;
  logic [7:0]                          green = '0;
  logic [7:0]                          blue = '0;
  logic                                start_of_frame = 1'b0;
  logic                                cue_valid;
  logic                                cue_ready = 1'b0;
  logic                                horizontal_valid;
  logic [newu_pkg::CUE_W-1:0]          horizontal_cue;
  logic                                vertical_valid;
  logic [newu_pkg::CUE_W-1:0]          vertical_cue;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [newu_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [newu_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  neighbor_edge_weight_unit dut (
    .clk              (clk),
    .rst              (rst),
    .pixel_valid      (pixel_valid),
    .pixel_ready      (pixel_ready),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .start_of_frame   (start_of_frame),
    .cue_valid        (cue_valid),
    .cue_ready        (cue_ready),
    .horizontal_valid (horizontal_valid),
    .horizontal_cue   (horizontal_cue),
    .vertical_valid   (vertical_valid),
    .vertical_cue     (vertical_cue),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [15:0] weight_lut [0:LUT_SIZE];
  logic [23:0] row_mem [0:ROW_DEPTH-1];
  bit          row_written [0:ROW_DEPTH-1];
  logic [23:0] left_px = '0;
  int          col_cnt = 0;
  bit          past_row = 1'b0;
  logic [10:0] width_reg = 11'd640;
  logic [15:0] floor_reg = 16'd9830;

  pending_t pixel_queue[$];
  cue_t     cue_expected[$];
  pending_t in_flight;

  int items_issued = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int failures = 0;
  int settings_run = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int stalled_cycles = 0;

  // ln(1 + exp(-x)) with x in Q31, rounded to Q0.16
  function automatic logic [15:0] ln1p_exp_neg(input longint unsigned x);
    longint unsigned n, r, term, u, z, z2, p, acc;
    longint          sum;
    n    = x >> 31;
    r    = x & (ONE_Q31 - 64'd1);
    sum  = longint'(ONE_Q31);
    term = ONE_Q31;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * r) >> 31) / 64'(k);
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    u = longint'(sum);
    if (n >= 64) begin
      u = 0;
    end else begin
      for (longint unsigned j = 0; j < n; j++) begin
        u = (u * EXP_M1_Q31) >> 31;
      end
    end
    z   = (u << 31) / (64'd2 * ONE_Q31 + u);
    z2  = (z * z) >> 31;
    p   = z;
    acc = 0;
    for (int k = 0; k < 16; k++) begin
      acc = acc + p / 64'(2 * k + 1);
      p   = (p * z2) >> 31;
    end
    acc = 64'd2 * acc;
    acc = (acc + 64'd16384) >> 15;
    if (acc > 64'd65535) begin
      acc = 64'd65535;
    end
    return acc[15:0];
  endfunction

  function automatic logic [15:0] pair_weight(input logic [23:0] a, input logic [23:0] b);
    int     dr, dg, db;
    longint d, t, k, frac, diff, v;
    dr = int'(a[23:16]) - int'(b[23:16]);
    dg = int'(a[15:8]) - int'(b[15:8]);
    db = int'(a[7:0]) - int'(b[7:0]);
    d  = longint'(dr * dr + dg * dg + db * db);
    t  = d * LUT_SIZE;
    k  = t / SPAN;
    frac = t % SPAN;
    if (k >= LUT_SIZE) begin
      v = longint'(weight_lut[LUT_SIZE]);
    end else begin
      diff = longint'(weight_lut[k + 1]) - longint'(weight_lut[k]);
      v    = longint'(weight_lut[k]) + diff * frac / SPAN;
    end
    if (v < longint'(floor_reg)) begin
      v = longint'(floor_reg);
    end
    return v[15:0];
  endfunction

  function automatic int effective_width(input logic [10:0] w);
    if (w < 11'd2) begin
      return 2;
    end
    if (w > 11'(ROW_DEPTH)) begin
      return ROW_DEPTH;
    end
    return int'(w);
  endfunction

  function automatic cue_t predict_cues(input logic [23:0] px, input logic sof);
    cue_t c;
    int   col;
    c = '0;
    if (sof) begin
      col_cnt  = 0;
      past_row = 1'b0;
    end
    col = col_cnt;
    if (col > 0) begin
      c.h_valid = 1'b1;
      c.h_cue   = pair_weight(left_px, px);
    end
    if (past_row) begin
      c.v_valid = 1'b1;
      c.v_cue   = pair_weight(row_mem[col], px);
    end
    row_mem[col]     = px;
    row_written[col] = 1'b1;
    left_px          = px;
    if (col + 1 >= effective_width(width_reg)) begin
      col_cnt  = 0;
      past_row = 1'b1;
    end else begin
      col_cnt = col + 1;
    end
    return c;
  endfunction

  // a pixel that would compare against a never-written row entry starts a new frame
  function automatic void queue_pixel(input logic [23:0] px, input logic sof);
    pending_t it;
    logic     start;
    start = sof;
    if (!start && past_row && !row_written[col_cnt]) begin
      start = 1'b1;
    end
    it.red   = px[23:16];
    it.green = px[15:8];
    it.blue  = px[7:0];
    it.sof   = start;
    it.cues  = predict_cues(px, start);
    pixel_queue.insert(pixel_queue.size(), it);
    items_issued++;
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] c, input int s);
    int v;
    v = int'(c) + int'($urandom_range(2 * s)) - s;
    if (v < 0) begin
      v = 0;
    end
    if (v > 255) begin
      v = 255;
    end
    return v[7:0];
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic write_reg(input logic [newu_pkg::CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == newu_pkg::REG_IMAGE_WIDTH) begin
      width_reg = data[10:0];
    end else begin
      floor_reg = data;
    end
  endtask

  task automatic wait_drained();
    while (results_checked != items_issued) begin
      @(posedge clk);
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) begin
        cue_expected.insert(cue_expected.size(), in_flight.cues);
        pixels_sent++;
      end
      if (!pixel_valid || pixel_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pixel_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_flight = pixel_queue.pop_front();
          red            <= in_flight.red;
          green          <= in_flight.green;
          blue           <= in_flight.blue;
          start_of_frame <= in_flight.sof;
          pixel_valid    <= 1'b1;
          if ($urandom_range(99) < send_idle_pct) begin
            send_gap = $urandom_range(19, 1);
          end
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // cue monitor
  always @(posedge clk) begin
    cue_t want;
    if (rst) begin
      cue_ready <= 1'b0;
    end else begin
      if (cue_valid && cue_ready) begin
        if (cue_expected.size() == 0) begin
          $error("cue item with no pixel waiting for it");
          failures++;
        end else begin
          want = cue_expected.pop_front();
          check_field("horizontal_valid", 16'(want.h_valid), 16'(horizontal_valid));
          check_field("horizontal_cue", want.h_cue, horizontal_cue);
          check_field("vertical_valid", 16'(want.v_valid), 16'(vertical_valid));
          check_field("vertical_cue", want.v_cue, vertical_cue);
        end
        results_checked++;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        cue_ready <= 1'b0;
      end else begin
        cue_ready <= 1'b1;
        if ($urandom_range(99) < recv_idle_pct) begin
          recv_stall = $urandom_range(19, 1);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((pixel_valid && pixel_ready) || (cue_valid && cue_ready) ||
          (cfg_valid && cfg_ready)) begin
        stalled_cycles <= 0;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("neighbor_edge_weight_unit_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [23:0]     px;
    logic [15:0]     wdata;
    logic [15:0]     fdata;
    logic            sof;
    int              n_items;
    int              spread;
    bit              begin_frame;
    longint unsigned x;

    for (int k = 0; k <= LUT_SIZE; k++) begin
      x = ((64'(k) * 64'(SPAN)) << 31) / 64'(LUT_SIZE * 6400);
      weight_lut[k] = ln1p_exp_neg(x);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero distance, mid-row restart, floor at both ends
    send_idle_pct = 10;
    recv_idle_pct = 10;
    write_reg(newu_pkg::REG_IMAGE_WIDTH, 16'd4);
    write_reg(newu_pkg::REG_FLOOR_WEIGHT, 16'd0);
    settings_run++;
    queue_pixel(24'h000000, 1'b1);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'hFF00FF, 1'b0);
    queue_pixel(24'h00FF00, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'h00FF00, 1'b0);
    queue_pixel(24'h00FF00, 1'b0);
    queue_pixel(24'h010203, 1'b0);
    queue_pixel(24'h808080, 1'b1);
    queue_pixel(24'h7F7F7F, 1'b0);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'hFE0001, 1'b0);
    wait_drained();

    write_reg(newu_pkg::REG_IMAGE_WIDTH, 16'hF803);
    write_reg(newu_pkg::REG_FLOOR_WEIGHT, 16'hFFFF);
    settings_run++;
    queue_pixel(24'h102030, 1'b1);
    queue_pixel(24'h102030, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'h102031, 1'b0);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'h55AA55, 1'b1);
    queue_pixel(24'hAA55AA, 1'b0);
    wait_drained();

    px = 24'h808080;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: wdata = 16'h0000;
        4: wdata = 16'h07FF;
        7: wdata = 16'hF801;
        9: wdata = 16'h0400;
        default: begin
          if ($urandom_range(9) < 7) begin
            wdata = 16'(($urandom_range(31) << 11) | $urandom_range(12, 2));
          end else begin
            wdata = 16'(($urandom_range(31) << 11) | $urandom_range(90, 13));
          end
        end
      endcase
      case (p)
        2: fdata = 16'hFFFF;
        5: fdata = 16'h0000;
        default: begin
          case ($urandom_range(3))
            0: fdata = 16'd9830;
            1: fdata = 16'($urandom_range(65535));
            2: fdata = 16'($urandom_range(3000));
            default: fdata = 16'($urandom_range(50000, 20000));
          endcase
        end
      endcase
      if ($urandom_range(1)) begin
        write_reg(newu_pkg::REG_IMAGE_WIDTH, wdata);
        write_reg(newu_pkg::REG_FLOOR_WEIGHT, fdata);
      end else begin
        write_reg(newu_pkg::REG_FLOOR_WEIGHT, fdata);
        write_reg(newu_pkg::REG_IMAGE_WIDTH, wdata);
      end
      settings_run++;

      if (p == PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        case ($urandom_range(2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 5;
          default: send_idle_pct = 20;
        endcase
        case ($urandom_range(2))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 5;
          default: recv_idle_pct = 20;
        endcase
      end
      case ($urandom_range(3))
        0: spread = 1;
        1: spread = 4;
        2: spread = 16;
        default: spread = 64;
      endcase
      begin_frame = (p == 0) || ($urandom_range(99) < 70);
      n_items = (effective_width(wdata[10:0]) >= 200) ? 120 : 110;

      for (int j = 0; j < n_items; j++) begin
        if ($urandom_range(99) < 30) begin
          px = 24'($urandom);
        end else begin
          px = {nudge(px[23:16], spread), nudge(px[15:8], spread), nudge(px[7:0], spread)};
        end
        sof = (j == 0 && begin_frame) || ($urandom_range(199) == 0);
        queue_pixel(px, sof);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (cue_expected.size() != 0) begin
      $error("%0d expected cue items never arrived", cue_expected.size());
      failures++;
    end

    $display("streamed %0d pixels over %0d width/floor settings (widths 2..1024, floors 0..65535)",
             pixels_sent, settings_run);
    $display("compared %0d cue items, %0d mismatches", results_checked, failures);
    if (failures == 0) begin
      $display("neighbor_edge_weight_unit_test: PASS");
    end else begin
      $display("neighbor_edge_weight_unit_test: FAIL");
    end
    $finish;
  end

endmodule
